// File: sv/dcfd_pkg.sv
// Shared types, constants and the sequencer program of the DCF77 frame decoder.
// Used by dcfd_seq and dcf77_pulse_frame_decoder; depends on nothing else.
`timescale 1ns / 1ps

package dcfd_pkg;

  // Bit store geometry.
  localparam int FRAME_BITS     = 61;
  localparam int MIN_FRAME_BITS = 59;
  localparam int CNT_W          = $clog2(FRAME_BITS + 1);
  localparam int ADDR_W         = $clog2(FRAME_BITS);

  // The frame check only looks at bits 15 to 58; they are gathered in a shift register.
  localparam int FB_FIRST = 15;
  localparam int FB_LAST  = 58;
  localparam int FB_N     = FB_LAST - FB_FIRST + 1;

  // Reset values of the configuration registers.
  localparam logic [7:0]  SLICE_RST = 8'd224;
  localparam logic [23:0] NOM_RST   = 24'd1000000;
  localparam logic [23:0] GAP_RST   = 24'd500000;
  localparam logic [23:0] TMO_RST   = 24'd2000000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLICE   = 2'd0;
  localparam logic [1:0] CFG_NOMINAL = 2'd1;
  localparam logic [1:0] CFG_GAP     = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  // Frame error codes.
  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_COUNT  = 3'd1;
  localparam logic [2:0] ERR_ZONE   = 3'd2;
  localparam logic [2:0] ERR_START  = 3'd3;
  localparam logic [2:0] ERR_MINUTE = 3'd4;
  localparam logic [2:0] ERR_HOUR   = 3'd5;
  localparam logic [2:0] ERR_DATE   = 3'd6;

  typedef enum logic [2:0] {
    CHK_NONE,
    CHK_COUNT,
    CHK_ZONE,
    CHK_START,
    CHK_PARITY
  } chk_e;

  // One control word of the check program.
  typedef struct packed {
    logic              rd;       // issue a store read at addr
    logic [ADDR_W-1:0] addr;
    logic              cap;      // take in the bit read in the previous step
    logic              par_clr;  // restart the parity sum with this bit
    chk_e              chk;
    logic [2:0]        err;      // code reported when the check fails
    logic              last;
  } ctl_t;

  typedef struct packed {
    logic       done;
    logic [2:0] err;
  } seq_res_t;

  // Step s reads bit FB_FIRST + s, and that bit is taken in at step s + 1.
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] ST_COUNT   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_ZONE    = STEP_W'(18 - FB_FIRST + 1);
  localparam logic [STEP_W-1:0] ST_START   = STEP_W'(20 - FB_FIRST + 1);
  localparam logic [STEP_W-1:0] ST_MIN_CLR = STEP_W'(21 - FB_FIRST + 1);
  localparam logic [STEP_W-1:0] ST_MIN_CHK = STEP_W'(28 - FB_FIRST + 1);
  localparam logic [STEP_W-1:0] ST_HR_CLR  = STEP_W'(29 - FB_FIRST + 1);
  localparam logic [STEP_W-1:0] ST_HR_CHK  = STEP_W'(35 - FB_FIRST + 1);
  localparam logic [STEP_W-1:0] ST_DT_CLR  = STEP_W'(36 - FB_FIRST + 1);
  localparam logic [STEP_W-1:0] ST_LAST    = STEP_W'(FB_LAST - FB_FIRST + 1);

  function automatic ctl_t ctl_rom(input logic [STEP_W-1:0] step);
    ctl_t c;
    c.rd      = (step < ST_LAST);
    c.addr    = ADDR_W'(32'(step) + FB_FIRST);
    c.cap     = (step != ST_COUNT) && (step <= ST_LAST);
    c.par_clr = 1'b0;
    c.chk     = CHK_NONE;
    c.err     = ERR_OK;
    c.last    = 1'b0;
    case (step)
      ST_COUNT: begin
        c.chk = CHK_COUNT;
        c.err = ERR_COUNT;
      end
      ST_ZONE: begin
        c.chk = CHK_ZONE;
        c.err = ERR_ZONE;
      end
      ST_START: begin
        c.chk = CHK_START;
        c.err = ERR_START;
      end
      ST_MIN_CLR: c.par_clr = 1'b1;
      ST_MIN_CHK: begin
        c.chk = CHK_PARITY;
        c.err = ERR_MINUTE;
      end
      ST_HR_CLR: c.par_clr = 1'b1;
      ST_HR_CHK: begin
        c.chk = CHK_PARITY;
        c.err = ERR_HOUR;
      end
      ST_DT_CLR: c.par_clr = 1'b1;
      ST_LAST: begin
        c.chk  = CHK_PARITY;
        c.err  = ERR_DATE;
        c.last = 1'b1;
      end
      default: ;
    endcase
    return c;
  endfunction

endpackage

// File: sv/dcf77_pulse_frame_decoder.sv
// Top level of the DCF77 pulse and frame decoder: configuration, bit store and result word.
// Depends on dcfd_pkg, dcfd_ram and dcfd_seq.
`timescale 1ns / 1ps

// One input word per received second pulse; one result word comes back for each.
// A pulse that does not close a minute passes from acceptance through the compare and
// store states to the result register. A pulse whose interval marks a minute boundary
// also runs the frame check, a 45-step microprogram that reads the bit store one bit per
// cycle. A new word is taken while the previous result still waits in the output
// register. Decoded time and flags on every result are those of the last frame that
// passed; configuration may only be written while the block is idle.

module dcf77_pulse_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  raw_sample_i,
  input  logic [23:0] interval_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_done_o,
  output logic [2:0]  error_code_o,
  output logic        time_valid_o,
  output logic        overflow_o,
  output logic [5:0]  second_index_o,
  output logic        bit_value_o,
  output logic [6:0]  minute_value_o,
  output logic [5:0]  hour_value_o,
  output logic [5:0]  day_value_o,
  output logic [2:0]  weekday_value_o,
  output logic [12:0] month_year_o,
  output logic [3:0]  flag_bits_o
);
  import dcfd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_SEQ   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [7:0]  slice_q;
  logic [23:0] nom_q, gap_m_q, tmo_m_q;

  logic [2:0]       state_q, state_d;
  logic             bit_q, bit_d;
  logic [24:0]      diff_q, diff_d;
  logic             gap_q, gap_d, tmo_q, tmo_d;
  logic [2:0]       err_q, err_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             valid_q, valid_d;
  logic             ovf_q, ovf_d;
  logic [5:0]       sec_q, sec_d;
  logic [42:0]      lat_time_q, lat_time_d;
  logic [3:0]       lat_flags_q, lat_flags_d;
  logic             out_valid_q, out_valid_d;
  logic             load_out;

  logic [23:0]      dev;
  logic             full;
  logic             seq_start;
  logic             ram_re, ram_rd;
  logic [ADDR_W-1:0] ram_raddr;
  seq_res_t         seq_res;
  logic [FB_N-1:0]  fb;

  logic [6:0]  mi;
  logic [5:0]  hr, dy;
  logic [2:0]  wd;
  logic [4:0]  mo;
  logic [7:0]  yr;
  logic [3:0]  fl;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= SLICE_RST;
      nom_q   <= NOM_RST;
      gap_m_q <= GAP_RST;
      tmo_m_q <= TMO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLICE:   slice_q <= cfg_data_i[7:0];
        CFG_NOMINAL: nom_q   <= cfg_data_i;
        CFG_GAP:     gap_m_q <= cfg_data_i;
        CFG_TIMEOUT: tmo_m_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  dcfd_ram #(
    .WIDTH (1),
    .DEPTH (FRAME_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_STORE) && !full),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (bit_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rd)
  );

  dcfd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (seq_start),
    .bit_count_i (cnt_q),
    .rd_en_o     (ram_re),
    .rd_addr_o   (ram_raddr),
    .rd_data_i   (ram_rd),
    .res_o       (seq_res),
    .frame_o     (fb)
  );

  // BCD fields, least significant bit first; fb[0] holds bit 15 of the frame.
  always_comb begin
    mi = 7'(fb[21-FB_FIRST +: 4]) + 7'(fb[25-FB_FIRST +: 3]) * 7'd10;
    hr = 6'(fb[29-FB_FIRST +: 4]) + 6'(fb[33-FB_FIRST +: 2]) * 6'd10;
    dy = 6'(fb[36-FB_FIRST +: 4]) + 6'(fb[40-FB_FIRST +: 2]) * 6'd10;
    wd = fb[42-FB_FIRST +: 3];
    mo = 5'(fb[45-FB_FIRST +: 4]) + (fb[49-FB_FIRST] ? 5'd10 : 5'd0);
    yr = 8'(fb[50-FB_FIRST +: 4]) + 8'(fb[54-FB_FIRST +: 4]) * 8'd10;
    fl = {fb[19-FB_FIRST], fb[17-FB_FIRST], fb[16-FB_FIRST], fb[15-FB_FIRST]};
  end

  assign dev  = diff_q[24] ? (~diff_q[23:0] + 24'd1) : diff_q[23:0];
  assign full = (cnt_q >= CNT_W'(FRAME_BITS));
  assign in_ready_o = (state_q == S_IDLE);
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign seq_start  = (state_q == S_CMP) && (dev > gap_m_q);

  always_comb begin
    state_d     = state_q;
    bit_d       = bit_q;
    diff_d      = diff_q;
    gap_d       = gap_q;
    tmo_d       = tmo_q;
    err_d       = err_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    ovf_d       = ovf_q;
    sec_d       = sec_q;
    lat_time_d  = lat_time_q;
    lat_flags_d = lat_flags_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          bit_d   = (raw_sample_i < slice_q);
          diff_d  = {1'b0, interval_us_i} - {1'b0, nom_q};
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        gap_d   = (dev > gap_m_q);
        tmo_d   = (dev > tmo_m_q);
        err_d   = ERR_OK;
        state_d = gap_d ? S_SEQ : S_STORE;
      end
      S_SEQ: begin
        if (seq_res.done) begin
          err_d   = seq_res.err;
          valid_d = (seq_res.err == ERR_OK);
          cnt_d   = '0;
          if (seq_res.err == ERR_OK) begin
            lat_time_d  = 43'({mo, yr, wd, dy, hr, mi});
            lat_flags_d = fl;
          end
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        sec_d = (cnt_q > CNT_W'(63)) ? 6'd63 : cnt_q[5:0];
        ovf_d = full;
        // A timeout clears validity even when this pulse just closed a good frame.
        valid_d = valid_q & ~tmo_q & ~full;
        if (!full) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      valid_q     <= 1'b0;
      lat_time_q  <= '0;
      lat_flags_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      lat_time_q  <= lat_time_d;
      lat_flags_q <= lat_flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    diff_q <= diff_d;
    gap_q  <= gap_d;
    tmo_q  <= tmo_d;
    err_q  <= err_d;
    ovf_q  <= ovf_d;
    sec_q  <= sec_d;
  end

  // Result word register, loaded only when the previous word has been taken.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      frame_done_o    <= gap_q;
      error_code_o    <= err_q;
      time_valid_o    <= valid_q;
      overflow_o      <= ovf_q;
      second_index_o  <= sec_q;
      bit_value_o     <= bit_q;
      minute_value_o  <= lat_time_q[6:0];
      hour_value_o    <= lat_time_q[12:7];
      day_value_o     <= lat_time_q[18:13];
      weekday_value_o <= lat_time_q[21:19];
      month_year_o    <= lat_time_q[34:22];
      flag_bits_o     <= lat_flags_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FRAME_BITS))
    else $error("bit counter ran past the store depth");

  a_seq_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_res.done |-> state_q == S_SEQ)
    else $error("frame check finished outside the check state");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o && time_valid_o) |-> error_code_o == ERR_OK)
    else $error("time reported valid after a failed frame");

endmodule

// File: sv/dcfd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dcfd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/dcfd_seq.sv
// Microcoded frame checker: walks the bit store under the program in dcfd_pkg.
// Depends on dcfd_pkg; reads the store through the top level's RAM.
`timescale 1ns / 1ps

module dcfd_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dcfd_pkg::CNT_W-1:0]   bit_count_i,
  output logic                         rd_en_o,
  output logic [dcfd_pkg::ADDR_W-1:0]  rd_addr_o,
  input  logic                         rd_data_i,
  output dcfd_pkg::seq_res_t           res_o,
  output logic [dcfd_pkg::FB_N-1:0]    frame_o
);
  import dcfd_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              par_q, par_d;
  logic [FB_N-1:0]   sh_q, sh_d;
  seq_res_t          res_q, res_d;
  ctl_t              ctl;
  logic              fail;

  assign ctl = ctl_rom(step_q);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    par_d  = par_q;
    sh_d   = sh_q;
    res_d  = '{done: 1'b0, err: res_q.err};
    fail   = 1'b0;

    if (busy_q) begin
      par_d = (ctl.par_clr ? 1'b0 : par_q) ^ (ctl.cap & rd_data_i);
      if (ctl.cap) begin
        sh_d = {rd_data_i, sh_q[FB_N-1:1]};
      end
      // The zone check sees bit 17 at the top of the shift register and bit 18 arriving.
      case (ctl.chk)
        CHK_COUNT:  fail = (bit_count_i < CNT_W'(MIN_FRAME_BITS));
        CHK_ZONE:   fail = (rd_data_i == sh_q[FB_N-1]);
        CHK_START:  fail = !rd_data_i;
        CHK_PARITY: fail = par_d;
        default:    fail = 1'b0;
      endcase
      step_d = step_q + STEP_W'(1);
      if (fail || ctl.last) begin
        busy_d = 1'b0;
        res_d  = '{done: 1'b1, err: fail ? ctl.err : ERR_OK};
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      res_q  <= '{done: 1'b0, err: ERR_OK};
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      res_q  <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    par_q <= par_d;
    sh_q  <= sh_d;
  end

  assign rd_en_o   = busy_q & ctl.rd;
  assign rd_addr_o = ctl.addr;
  assign res_o     = res_q;
  assign frame_o   = sh_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("check started while the program is still running");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |=> !res_o.done)
    else $error("completion held for more than one cycle");

  a_ok_full_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.done && res_o.err == ERR_OK) |-> $past(step_q) == ST_LAST)
    else $error("frame passed without the program reaching its last step");

endmodule
